@@ hw/rtl/hck_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hck_pkg
// Shared types, constants and ones' complement helper for the IPv4 header
// check and TTL decrement block.
// ----------------------------------------------------------------------------
package hck_pkg;

   localparam int HEADER_WORDS = 10;
   localparam int NUM_REGS     = 5;
   localparam int CSR_IDX_W    = 3;

   localparam logic [3:0] LAST_POS      = 4'(HEADER_WORDS - 1);
   localparam logic [3:0] TTL_POS       = 4'd4;
   localparam logic [3:0] CKSUM_POS     = 4'd5;
   localparam logic [3:0] DEST_HIGH_POS = 4'd8;

   localparam logic [1:0] VERDICT_BAD_CKSUM = 2'd0;
   localparam logic [1:0] VERDICT_EXPIRED   = 2'd1;
   localparam logic [1:0] VERDICT_LOCAL     = 2'd2;
   localparam logic [1:0] VERDICT_FORWARD   = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [15:0] base_sum;
      logic [15:0] ttl_word;
      logic [15:0] old_cksum;
      logic [31:0] dest_addr;
   } stage_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hck_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hck_if
// Valid/ready channels for header words and check results.
// ----------------------------------------------------------------------------
interface hck_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] hdr_word;
   logic        last_word;

   modport source (output valid, output hdr_word, output last_word, input ready);
   modport sink   (input valid, input hdr_word, input last_word, output ready);
endinterface

interface hck_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [2:0]  iface_index;
   logic [7:0]  new_ttl;
   logic [15:0] new_checksum;
   logic [31:0] dest_addr;

   modport source (output valid, output verdict, output iface_index, output new_ttl,
                   output new_checksum, output dest_addr, input ready);
   modport sink   (input valid, input verdict, input iface_index, input new_ttl,
                   input new_checksum, input dest_addr, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/hck_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hck_accum
// Collects header words, keeps the running ones' complement sum and hands
// the finished header summary to the check stage.
// ----------------------------------------------------------------------------
module hck_accum
   import hck_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   hck_req_if.sink    req,
   input  wire logic  stage_take,
   output stage_type  stage
);

   logic [3:0]  word_count_ff,  word_count_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [15:0] ttl_word_ff,    ttl_word_in;
   logic [15:0] old_cksum_ff,   old_cksum_in;
   logic [15:0] dest_high_ff,   dest_high_in;
   stage_type   stage_ff,       stage_in;
   logic        fire;

   assign req.ready = !stage_ff.valid || stage_take;
   assign fire      = req.valid && req.ready;
   assign stage     = stage_ff;

   always_comb begin
      word_count_in  = word_count_ff;
      running_sum_in = running_sum_ff;
      ttl_word_in    = ttl_word_ff;
      old_cksum_in   = old_cksum_ff;
      dest_high_in   = dest_high_ff;
      stage_in       = stage_ff;
      if (stage_take) begin
         stage_in.valid = 1'b0;
      end
      if (fire) begin
         if (req.last_word) begin
            stage_in.valid     = 1'b1;
            stage_in.base_sum  = oc_add(running_sum_ff, req.hdr_word);
            stage_in.ttl_word  = ttl_word_ff;
            stage_in.old_cksum = old_cksum_ff;
            stage_in.dest_addr = {dest_high_ff, req.hdr_word};
            word_count_in      = '0;
            running_sum_in     = '0;
            ttl_word_in        = '0;
            old_cksum_in       = '0;
            dest_high_in       = '0;
         end else begin
            if (word_count_ff == TTL_POS) begin
               ttl_word_in = req.hdr_word;
            end else if (word_count_ff == CKSUM_POS) begin
               old_cksum_in = req.hdr_word;
            end else if (word_count_ff < LAST_POS) begin
               running_sum_in = oc_add(running_sum_ff, req.hdr_word);
               if (word_count_ff == DEST_HIGH_POS) begin
                  dest_high_in = req.hdr_word;
               end
            end
            if (word_count_ff < LAST_POS) begin
               word_count_in = word_count_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff  <= '0;
         running_sum_ff <= '0;
         ttl_word_ff    <= '0;
         old_cksum_ff   <= '0;
         dest_high_ff   <= '0;
         stage_ff       <= '0;
      end else begin
         word_count_ff  <= word_count_in;
         running_sum_ff <= running_sum_in;
         ttl_word_ff    <= ttl_word_in;
         old_cksum_ff   <= old_cksum_in;
         dest_high_ff   <= dest_high_in;
         stage_ff       <= stage_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/hck_verdict.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hck_verdict
// Checks the header checksum and TTL, matches the destination against the
// interface addresses and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module hck_verdict
   import hck_pkg::*;
#(
   parameter int NUM_IFACES = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire stage_type   stage,
   input  wire logic [31:0] iface_addr [NUM_IFACES],
   output logic             stage_take,
   hck_rsp_if.source        rsp
);

   logic        rsp_valid_ff;
   logic [1:0]  verdict_ff,   verdict_in;
   logic [2:0]  index_ff,     index_in;
   logic [7:0]  new_ttl_ff,   new_ttl_in;
   logic [15:0] new_cksum_ff, new_cksum_in;
   logic [31:0] dest_ff;
   logic [15:0] check;
   logic [7:0]  ttl;
   logic        hit;
   logic [2:0]  hit_index;

   assign stage_take = stage.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      check        = ~oc_add(stage.base_sum, stage.ttl_word);
      ttl          = stage.ttl_word[15:8];
      new_ttl_in   = (ttl == 8'd0) ? 8'd0 : ttl - 8'd1;
      new_cksum_in = ~oc_add(stage.base_sum, {new_ttl_in, stage.ttl_word[7:0]});
      hit          = 1'b0;
      hit_index    = '0;
      for (int i = NUM_IFACES - 1; i >= 0; i--) begin
         if (iface_addr[i] == stage.dest_addr) begin
            hit       = 1'b1;
            hit_index = 3'(i);
         end
      end
      index_in = '0;
      if (check != stage.old_cksum) begin
         verdict_in = VERDICT_BAD_CKSUM;
      end else if (ttl <= 8'd1) begin
         verdict_in = VERDICT_EXPIRED;
      end else if (hit) begin
         verdict_in = VERDICT_LOCAL;
         index_in   = hit_index;
      end else begin
         verdict_in = VERDICT_FORWARD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         verdict_ff   <= verdict_in;
         index_ff     <= index_in;
         new_ttl_ff   <= new_ttl_in;
         new_cksum_ff <= new_cksum_in;
         dest_ff      <= stage.dest_addr;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.verdict      = verdict_ff;
   assign rsp.iface_index  = index_ff;
   assign rsp.new_ttl      = new_ttl_ff;
   assign rsp.new_checksum = new_cksum_ff;
   assign rsp.dest_addr    = dest_ff;

endmodule
`default_nettype wire

@@ hw/rtl/ipv4_header_check_ttl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_header_check_ttl
// IPv4 header checksum check, TTL decrement and local address match.
// ----------------------------------------------------------------------------
// accepts one header word per cycle, no gaps between headers, while the
// result channel is not stalling; after the final word, the summary register
// and then the result register carry the outcome and hold it during a stall
// synchronous reset clears all sums, counts, valids and interface addresses
// ----------------------------------------------------------------------------
module ipv4_header_check_ttl
   import hck_pkg::*;
#(
   parameter int NUM_IFACES = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   hck_req_if.sink                   req,
   hck_rsp_if.source                 rsp,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   logic [31:0] iface_addr_ff [NUM_IFACES];
   stage_type   stage;
   logic        stage_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_IFACES; i++) begin
            iface_addr_ff[i] <= '0;
         end
      end else if (csr_we) begin
         for (int i = 0; i < NUM_IFACES; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               iface_addr_ff[i] <= csr_wdata;
            end
         end
      end
   end

   hck_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .stage_take (stage_take),
      .stage      (stage)
   );

   hck_verdict #(
      .NUM_IFACES (NUM_IFACES)
   ) u_verdict (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .iface_addr (iface_addr_ff),
      .stage_take (stage_take),
      .rsp        (rsp)
   );

`ifndef ASSERT_OFF
   a_last_loads_stage: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last_word) |=> stage.valid)
      else $error("final word did not load the summary stage");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(stage.valid))
      else $error("result appeared without a summary");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("input taken while both stages are blocked");
`endif

endmodule
`default_nettype wire
